/* rtl/core/moving_circle_box_entry_test_defines.svh */
// Assertion macros for the moving circle box entry test block.
// Included by the top-level RTL file, which checks its own pipeline behavior.
// No dependencies.
`ifndef MOVING_CIRCLE_BOX_ENTRY_TEST_DEFINES_SVH
`define MOVING_CIRCLE_BOX_ENTRY_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MCB_ASSERT_NOW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mcb check failed");

`define MCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcb check failed");

`define MCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcb check failed");

`else

`define MCB_ASSERT_NOW(label, clk, rst_n, cond)
`define MCB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/mcb_pkg.sv */
// Shared types and constants for the moving circle box entry test.
// Used by every module of the block; no dependencies.
package mcb_pkg;

    localparam int COORD_WIDTH_DEF = 31;

    typedef enum logic [1:0] {
        AX_EMPTY,
        AX_ALL,
        AX_SPAN
    } axis_kind_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

/* rtl/core/mcb_axis_lane.sv */
// One axis lane: shrinks the slab by the radius and finds the entry and exit times
// as fractions over the speed. Two register stages. Depends on mcb_pkg.
module mcb_axis_lane #(
    parameter int COORD_WIDTH = mcb_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcb_pkg::stage_en_t            en,
    input  logic signed [COORD_WIDTH-1:0] pos,
    input  logic signed [COORD_WIDTH-1:0] vel,
    input  logic signed [COORD_WIDTH-1:0] bound_lo,
    input  logic signed [COORD_WIDTH-1:0] bound_hi,
    input  logic        [COORD_WIDTH-2:0] radius,
    output mcb_pkg::axis_kind_t           kind,
    output logic        [COORD_WIDTH:0]   t_start,
    output logic        [COORD_WIDTH:0]   t_end,
    output logic        [COORD_WIDTH-1:0] den
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] p_reg;
    logic signed [W-1:0] v_reg;
    logic signed [W:0]   lo_reg;
    logic signed [W:0]   hi_reg;
    logic signed [W:0]   lo_next;
    logic signed [W:0]   hi_next;

    logic signed [W+1:0] d_lo;
    logic signed [W+1:0] d_hi;
    logic signed [W+1:0] neg_d_lo;
    logic signed [W+1:0] neg_d_hi;
    logic                lo_above_p;
    logic                hi_below_p;
    logic                slab_empty;
    logic                v_zero;
    logic [W-1:0]        v_abs;

    mcb_pkg::axis_kind_t kind_reg;
    mcb_pkg::axis_kind_t kind_next;
    logic [W:0]          start_reg;
    logic [W:0]          start_next;
    logic [W:0]          end_reg;
    logic [W:0]          end_next;
    logic [W-1:0]        den_reg;

    assign lo_next = $signed({bound_lo[W-1], bound_lo}) + $signed({2'b00, radius});
    assign hi_next = $signed({bound_hi[W-1], bound_hi}) - $signed({2'b00, radius});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p_reg  <= pos;
            v_reg  <= vel;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign d_lo       = $signed({lo_reg[W], lo_reg}) - $signed({{2{p_reg[W-1]}}, p_reg});
    assign d_hi       = $signed({hi_reg[W], hi_reg}) - $signed({{2{p_reg[W-1]}}, p_reg});
    assign neg_d_lo   = -d_lo;
    assign neg_d_hi   = -d_hi;
    assign lo_above_p = !d_lo[W+1] && (d_lo != '0);
    assign hi_below_p = d_hi[W+1];
    assign slab_empty = lo_reg > hi_reg;
    assign v_zero     = (v_reg == '0);
    assign v_abs      = v_reg[W-1] ? (~v_reg + 1'b1) : v_reg;

    always_comb
    begin
        kind_next  = mcb_pkg::AX_EMPTY;
        start_next = '0;
        end_next   = '0;
        if (v_zero)
        begin
            if (!lo_above_p && !hi_below_p)
            begin
                kind_next = mcb_pkg::AX_ALL;
            end
        end
        else if (!slab_empty)
        begin
            if (!v_reg[W-1])
            begin
                if (!hi_below_p)
                begin
                    kind_next  = mcb_pkg::AX_SPAN;
                    start_next = lo_above_p ? d_lo[W:0] : '0;
                    end_next   = d_hi[W:0];
                end
            end
            else
            begin
                if (!lo_above_p)
                begin
                    kind_next  = mcb_pkg::AX_SPAN;
                    start_next = hi_below_p ? neg_d_hi[W:0] : '0;
                    end_next   = neg_d_lo[W:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= mcb_pkg::AX_EMPTY;
        end
        else if (en.s2)
        begin
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            den_reg   <= v_abs;
        end
    end

    assign kind    = kind_reg;
    assign t_start = start_reg;
    assign t_end   = end_reg;
    assign den     = den_reg;

endmodule

/* rtl/core/mcb_wide_mul.sv */
// Cross-product lane: unsigned multiply split into four half-width partial
// products (stage 3) and summed (stage 4). Depends on mcb_pkg.
module mcb_wide_mul #(
    parameter int A_W = mcb_pkg::COORD_WIDTH_DEF + 1,
    parameter int B_W = mcb_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  mcb_pkg::stage_en_t   en,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]   prod
);

    localparam int AL  = (A_W + 1) / 2;
    localparam int AH  = A_W - AL;
    localparam int BL  = (B_W + 1) / 2;
    localparam int BH  = B_W - BL;
    localparam int P_W = A_W + B_W;

    logic [AL+BL-1:0] pll_reg;
    logic [AL+BH-1:0] plh_reg;
    logic [AH+BL-1:0] phl_reg;
    logic [AH+BH-1:0] phh_reg;
    logic [P_W-1:0]   prod_reg;
    logic [P_W-1:0]   prod_next;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            pll_reg <= a[AL-1:0]   * b[BL-1:0];
            plh_reg <= a[AL-1:0]   * b[B_W-1:BL];
            phl_reg <= a[A_W-1:AL] * b[BL-1:0];
            phh_reg <= a[A_W-1:AL] * b[B_W-1:BL];
        end
    end

    assign prod_next = {phh_reg, pll_reg}
                     + (P_W'(plh_reg) << BL)
                     + (P_W'(phl_reg) << AL);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/mcb_merge.sv */
// Merge stage: carries both axis kinds alongside the products and combines
// the two time intervals into the final answer. Depends on mcb_pkg.
module mcb_merge #(
    parameter int P_W = 2 * mcb_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcb_pkg::stage_en_t  en,
    input  mcb_pkg::axis_kind_t kind_x,
    input  mcb_pkg::axis_kind_t kind_y,
    input  logic [P_W-1:0]      xs_yd,
    input  logic [P_W-1:0]      ye_xd,
    input  logic [P_W-1:0]      ys_xd,
    input  logic [P_W-1:0]      xe_yd,
    output logic                fits
);

    mcb_pkg::axis_kind_t kx3_reg;
    mcb_pkg::axis_kind_t ky3_reg;
    mcb_pkg::axis_kind_t kx4_reg;
    mcb_pkg::axis_kind_t ky4_reg;
    logic                fits_reg;
    logic                fits_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kx3_reg  <= mcb_pkg::AX_EMPTY;
            ky3_reg  <= mcb_pkg::AX_EMPTY;
            kx4_reg  <= mcb_pkg::AX_EMPTY;
            ky4_reg  <= mcb_pkg::AX_EMPTY;
            fits_reg <= 1'b0;
        end
        else
        begin
            if (en.s3)
            begin
                kx3_reg <= kind_x;
                ky3_reg <= kind_y;
            end
            if (en.s4)
            begin
                kx4_reg <= kx3_reg;
                ky4_reg <= ky3_reg;
            end
            if (en.s5)
            begin
                fits_reg <= fits_next;
            end
        end
    end

    always_comb
    begin
        if (kx4_reg == mcb_pkg::AX_EMPTY || ky4_reg == mcb_pkg::AX_EMPTY)
        begin
            fits_next = 1'b0;
        end
        else if (kx4_reg == mcb_pkg::AX_ALL || ky4_reg == mcb_pkg::AX_ALL)
        begin
            fits_next = 1'b1;
        end
        else
        begin
            fits_next = (xs_yd <= ye_xd) && (ys_xd <= xe_yd);
        end
    end

    assign fits = fits_reg;

endmodule

/* rtl/core/moving_circle_box_entry_test.sv */
// Moving circle box entry test, top level.
// Input word: circle, velocity and box; output word: one fits_sometime flag.
// Fully pipelined, one word per clock cycle when the receiver keeps up.
// Pipeline depth: five register stages between a word accepted on s_tdata
// and its result on m_tvalid/m_tdata.
// Stage 1 shrinks each slab by the radius, stage 2 finds per-axis entry and
// exit times, stage 3 forms partial cross products, stage 4 sums them, stage 5
// compares and merges the two axes into the output register.
// Each stage holds its word until the next one frees up, so bubbles collapse
// and s_tready stays high while any stage is empty. With m_tready low and all
// five stages full, s_tready drops; no word is lost or repeated.
// Reset clears all stage valid flags; s_tready is high right after reset.
// Depends on mcb_pkg, mcb_axis_lane, mcb_wide_mul, mcb_merge and the
// assertion macro header.
`include "moving_circle_box_entry_test_defines.svh"

module moving_circle_box_entry_test #(
    parameter int COORD_WIDTH = mcb_pkg::COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, radius (COORD_WIDTH-1 bits), vel_x, vel_y,
    // box_left, box_bottom, box_right, box_top; zero padded to bytes
    input  logic [8*((9*COORD_WIDTH+6)/8)-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // fits_sometime; zero padded to a byte
    output logic [7:0] m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int N_W = W + 1;
    localparam int P_W = N_W + W;

    mcb_pkg::stage_en_t en;
    logic [5:1]         valid_reg;
    logic [5:1]         valid_next;

    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic [W-2:0]        radius;
    logic signed [W-1:0] vel_x;
    logic signed [W-1:0] vel_y;
    logic signed [W-1:0] box_left;
    logic signed [W-1:0] box_bottom;
    logic signed [W-1:0] box_right;
    logic signed [W-1:0] box_top;

    mcb_pkg::axis_kind_t kind_x;
    mcb_pkg::axis_kind_t kind_y;
    logic [N_W-1:0]      xs;
    logic [N_W-1:0]      xe;
    logic [W-1:0]        xd;
    logic [N_W-1:0]      ys;
    logic [N_W-1:0]      ye;
    logic [W-1:0]        yd;
    logic [P_W-1:0]      xs_yd;
    logic [P_W-1:0]      ye_xd;
    logic [P_W-1:0]      ys_xd;
    logic [P_W-1:0]      xe_yd;
    logic                fits;

    assign center_x   = s_tdata[W-1:0];
    assign center_y   = s_tdata[2*W-1:W];
    assign radius     = s_tdata[3*W-2:2*W];
    assign vel_x      = s_tdata[4*W-2:3*W-1];
    assign vel_y      = s_tdata[5*W-2:4*W-1];
    assign box_left   = s_tdata[6*W-2:5*W-1];
    assign box_bottom = s_tdata[7*W-2:6*W-1];
    assign box_right  = s_tdata[8*W-2:7*W-1];
    assign box_top    = s_tdata[9*W-2:8*W-1];

    always_comb
    begin
        en.s5 = !valid_reg[5] || m_tready;
        en.s4 = !valid_reg[4] || en.s5;
        en.s3 = !valid_reg[3] || en.s4;
        en.s2 = !valid_reg[2] || en.s3;
        en.s1 = !valid_reg[1] || en.s2;
        valid_next[1] = en.s1 ? s_tvalid     : valid_reg[1];
        valid_next[2] = en.s2 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = en.s3 ? valid_reg[2] : valid_reg[3];
        valid_next[4] = en.s4 ? valid_reg[3] : valid_reg[4];
        valid_next[5] = en.s5 ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    mcb_axis_lane #(.COORD_WIDTH(W)) u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .pos      (center_x),
        .vel      (vel_x),
        .bound_lo (box_left),
        .bound_hi (box_right),
        .radius   (radius),
        .kind     (kind_x),
        .t_start  (xs),
        .t_end    (xe),
        .den      (xd)
    );

    mcb_axis_lane #(.COORD_WIDTH(W)) u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .pos      (center_y),
        .vel      (vel_y),
        .bound_lo (box_bottom),
        .bound_hi (box_top),
        .radius   (radius),
        .kind     (kind_y),
        .t_start  (ys),
        .t_end    (ye),
        .den      (yd)
    );

    mcb_wide_mul #(.A_W(N_W), .B_W(W)) u_mul_xs_yd (
        .clk (clk), .en (en), .a (xs), .b (yd), .prod (xs_yd)
    );

    mcb_wide_mul #(.A_W(N_W), .B_W(W)) u_mul_ye_xd (
        .clk (clk), .en (en), .a (ye), .b (xd), .prod (ye_xd)
    );

    mcb_wide_mul #(.A_W(N_W), .B_W(W)) u_mul_ys_xd (
        .clk (clk), .en (en), .a (ys), .b (xd), .prod (ys_xd)
    );

    mcb_wide_mul #(.A_W(N_W), .B_W(W)) u_mul_xe_yd (
        .clk (clk), .en (en), .a (xe), .b (yd), .prod (xe_yd)
    );

    mcb_merge #(.P_W(P_W)) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .kind_x (kind_x),
        .kind_y (kind_y),
        .xs_yd  (xs_yd),
        .ye_xd  (ye_xd),
        .ys_xd  (ys_xd),
        .xe_yd  (xe_yd),
        .fits   (fits)
    );

    assign s_tready = en.s1;
    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {7'b0000000, fits};

    `MCB_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, s_tvalid && s_tready, valid_reg[1])
    `MCB_ASSERT_IMPL(a_full_stall_blocks, clk, rst_n, (&valid_reg) && !m_tready, !s_tready)
    `MCB_ASSERT_IMPL(a_empty_s1_ready, clk, rst_n, !valid_reg[1], s_tready)
    `MCB_ASSERT_NEXT(a_stall_holds_result, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))

endmodule

/* tb/tb_moving_circle_box_entry_test.sv */
// Testbench for moving_circle_box_entry_test: directed table with fixed or predicted
// results, then random queries checked against an in-bench fits predictor, with random stalls on both streams.
// Depends on mcb_pkg and the moving_circle_box_entry_test RTL.
`timescale 1ns / 100ps

module tb_moving_circle_box_entry_test;

    localparam int COORD_W      = mcb_pkg::COORD_WIDTH_DEF;
    localparam int TDATA_W      = 8 * ((9 * COORD_W + 6) / 8);
    localparam int RANDOM_WORDS = 1200;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint RADIUS_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-2:0]        radius_t;

    typedef struct packed {
        coord_t  top;
        coord_t  right;
        coord_t  bottom;
        coord_t  left;
        coord_t  vy;
        coord_t  vx;
        radius_t radius;
        coord_t  cy;
        coord_t  cx;
    } query_t;

    localparam int QUERY_W = $bits(query_t);

    typedef struct {
        mcb_pkg::axis_kind_t kind;
        logic [63:0]         start;
        logic [63:0]         stop;
        logic [63:0]         den;
    } axis_window_t;

    typedef enum logic [1:0] {
        PREDICTED,
        FITS_NO,
        FITS_YES
    } row_expect_t;

    typedef struct {
        query_t      q;
        row_expect_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // cx, cy, radius, vx, vy, left, bottom, right, top; 0 pad
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;   // fits_sometime; 0 pad

    bit   fits_expected[$];
    int   mismatches;
    int   words_accepted;
    logic stall_hold = 1'b0;
    int   ready_stall;
    int   rx_cycles;

    moving_circle_box_entry_test #(
        .COORD_WIDTH(COORD_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic axis_window_t axis_window(longint p, longint v, longint lo_b,
                                                 longint hi_b, longint r);
        axis_window_t w;
        longint lo;
        longint hi;
        lo      = lo_b + r;
        hi      = hi_b - r;
        w.kind  = mcb_pkg::AX_EMPTY;
        w.start = 0;
        w.stop  = 0;
        w.den   = 1;
        if (v == 0)
        begin
            if (lo <= p && p <= hi)
                w.kind = mcb_pkg::AX_ALL;
            return w;
        end
        if (lo > hi)
            return w;
        if (v > 0)
        begin
            if (p > hi)
                return w;
            w.start = (lo > p) ? lo - p : 0;
            w.stop  = hi - p;
            w.den   = v;
        end
        else
        begin
            if (p < lo)
                return w;
            w.start = (p > hi) ? p - hi : 0;
            w.stop  = p - lo;
            w.den   = -v;
        end
        w.kind = mcb_pkg::AX_SPAN;
        return w;
    endfunction

    // a/b <= c/d with positive denominators, exact
    function automatic bit ratio_le(logic [63:0] a, logic [63:0] b,
                                    logic [63:0] c, logic [63:0] d);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = 128'(a) * 128'(d);
        rhs = 128'(c) * 128'(b);
        return lhs <= rhs;
    endfunction

    function automatic bit predict_fits(query_t q);
        axis_window_t wx;
        axis_window_t wy;
        wx = axis_window(q.cx, q.vx, q.left, q.right, longint'(q.radius));
        wy = axis_window(q.cy, q.vy, q.bottom, q.top, longint'(q.radius));
        if (wx.kind == mcb_pkg::AX_EMPTY || wy.kind == mcb_pkg::AX_EMPTY)
            return 1'b0;
        if (wx.kind == mcb_pkg::AX_ALL || wy.kind == mcb_pkg::AX_ALL)
            return 1'b1;
        return ratio_le(wx.start, wx.den, wy.stop, wy.den) &&
               ratio_le(wy.start, wy.den, wx.stop, wx.den);
    endfunction

    function automatic stim_row_t stim_row(longint cx, longint cy, longint r, longint vx,
                                           longint vy, longint l, longint b, longint rt,
                                           longint t, row_expect_t want);
        stim_row_t s;
        s.q.cx     = coord_t'(cx);
        s.q.cy     = coord_t'(cy);
        s.q.radius = radius_t'(r);
        s.q.vx     = coord_t'(vx);
        s.q.vy     = coord_t'(vy);
        s.q.left   = coord_t'(l);
        s.q.bottom = coord_t'(b);
        s.q.right  = coord_t'(rt);
        s.q.top    = coord_t'(t);
        s.want     = want;
        return s;
    endfunction

    function automatic coord_t rand_coord(bit narrow);
        if (narrow)
            return coord_t'(int'($urandom_range(0, 128)) - 64);
        case ($urandom_range(0, 9))
            0:       return coord_t'(COORD_MIN);
            1:       return coord_t'(COORD_MAX);
            2:       return '0;
            3:       return '1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t rand_velocity(bit narrow);
        if ($urandom_range(0, 4) == 0)
            return '0;
        if (narrow)
            return coord_t'(int'($urandom_range(0, 18)) - 9);
        return rand_coord(1'b0);
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     mode;
        bit     narrow;
        coord_t lo[2];
        coord_t hi[2];
        coord_t c[2];
        coord_t swap;
        longint half;
        longint span;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            q = QUERY_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom});
            return q;
        end
        narrow = (mode <= 5);
        half   = RADIUS_MAX;
        for (int a = 0; a < 2; a++)
        begin
            lo[a] = rand_coord(narrow);
            hi[a] = rand_coord(narrow);
            if (lo[a] > hi[a])
            begin
                swap  = lo[a];
                lo[a] = hi[a];
                hi[a] = swap;
            end
            span = longint'(hi[a]) - longint'(lo[a]);
            if (span / 2 < half)
                half = span / 2;
            if (narrow)
                c[a] = coord_t'(int'($urandom_range(0, 256)) - 128);
            else if ($urandom_range(0, 1) == 0)
                c[a] = rand_coord(1'b0);
            else
                c[a] = coord_t'(longint'(lo[a]) + longint'($urandom_range(0, 32'(span))));
            if ($urandom_range(0, 15) == 0)
            begin
                swap  = lo[a];
                lo[a] = hi[a];
                hi[a] = swap;
            end
        end
        case ($urandom_range(0, 7))
            0:       q.radius = radius_t'((half < RADIUS_MAX) ? half + 1 : half);
            1, 2:    q.radius = radius_t'($urandom_range(0, 32'(half)));
            default: q.radius = radius_t'($urandom_range(0, 32'(half / 16)));
        endcase
        q.cx     = c[0];
        q.cy     = c[1];
        q.left   = lo[0];
        q.right  = hi[0];
        q.bottom = lo[1];
        q.top    = hi[1];
        q.vx     = rand_velocity(narrow);
        q.vy     = rand_velocity(narrow);
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        if (words_accepted % 200 < 40)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_query(input query_t q, input bit fits);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(q);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fits_expected.push_back(fits);
        words_accepted++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_stall <= 0;
            rx_cycles   <= 0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            if (stall_hold)
                m_tready <= 1'b0;
            else if (ready_stall > 0)
            begin
                m_tready    <= 1'b0;
                ready_stall <= ready_stall - 1;
            end
            else if (rx_cycles % 256 < 60)
                m_tready <= 1'b1;
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:
                    begin
                        m_tready    <= 1'b0;
                        ready_stall <= $urandom_range(0, 2);
                    end
                    4:
                    begin
                        m_tready    <= 1'b0;
                        ready_stall <= $urandom_range(14, 39);
                    end
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    // hold the receiver off so the pipeline fills and backs up the input
    initial
    begin
        wait (words_accepted >= 500);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : fits_check
        bit want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (fits_expected.size() == 0)
            begin
                $error("fits_sometime: unexpected word, expected none, actual %0d", m_tdata[0]);
                mismatches++;
            end
            else
            begin
                want = fits_expected.pop_front();
                if (m_tdata[0] !== want)
                begin
                    $error("fits_sometime mismatch: expected %0d, actual %0d", want, m_tdata[0]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        query_t    q;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(stim_row(0, 0, 0, 0, 0, 0, 0, 0, 0, FITS_YES));
        rows.push_back(stim_row(0, 0, 0, 0, 0, 10, -5, -10, 5, FITS_NO));
        rows.push_back(stim_row(0, 0, RADIUS_MAX, 0, 0, COORD_MIN, COORD_MIN, COORD_MAX,
                                COORD_MAX, FITS_YES));
        rows.push_back(stim_row(1, 0, RADIUS_MAX, 0, 0, COORD_MIN, COORD_MIN, COORD_MAX,
                                COORD_MAX, FITS_NO));
        rows.push_back(stim_row(0, 0, RADIUS_MAX, 1, 1, -100, -100, 100, 100, FITS_NO));
        rows.push_back(stim_row(200, 0, 0, 5, 0, -100, -100, 100, 100, FITS_NO));
        rows.push_back(stim_row(-200, 0, 0, 0, -3, -100, -100, 100, 100, FITS_NO));
        rows.push_back(stim_row(COORD_MIN, 0, 0, COORD_MAX, 0, -10, -10, 10, 10, FITS_YES));
        rows.push_back(stim_row(0, 0, 0, 1, 1, 1, 3, 2, 4, FITS_NO));
        rows.push_back(stim_row(0, 0, 0, 1, 1, 1, 3, 3, 4, FITS_YES));
        rows.push_back(stim_row(10, 10, 5, 0, 0, 5, 5, 15, 15, FITS_YES));
        rows.push_back(stim_row(COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MIN, COORD_MIN,
                                COORD_MIN, COORD_MIN, COORD_MIN, PREDICTED));
        rows.push_back(stim_row(COORD_MAX, COORD_MAX, RADIUS_MAX, COORD_MAX, COORD_MAX,
                                COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, FITS_NO));
        rows.push_back(stim_row(-1, -1, RADIUS_MAX, -1, -1, -1, -1, -1, -1, PREDICTED));
        rows.push_back(stim_row(0, 0, 0, -1, -1, -4, -6, -3, -5, PREDICTED));
        rows.push_back(stim_row(COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, COORD_MIN,
                                COORD_MIN, COORD_MAX, COORD_MAX, PREDICTED));
        rows.push_back(stim_row(5, 5, 0, 3, 7, 6, 6, 20, 20, PREDICTED));
        rows.push_back(stim_row(100, -100, 0, -7, 11, -50, -50, 50, 50, PREDICTED));
        rows.push_back(stim_row(0, 0, 2, 2, -2, -1, -1, 1, 1, FITS_NO));
        rows.push_back(stim_row(COORD_MIN, COORD_MAX, 0, 1, -1, COORD_MIN, COORD_MIN,
                                COORD_MAX, COORD_MAX, PREDICTED));

        foreach (rows[i])
        begin
            if (rows[i].want == PREDICTED)
                send_query(rows[i].q, predict_fits(rows[i].q));
            else
                send_query(rows[i].q, rows[i].want == FITS_YES);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            q = random_query();
            send_query(q, predict_fits(q));
        end
        s_tvalid <= 1'b0;

        while (fits_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_moving_circle_box_entry_test passed");
        else
            $display("tb_moving_circle_box_entry_test failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb_moving_circle_box_entry_test failed");
        $finish;
    end

endmodule
